>>> hw/rtl/lsm_pkg.sv
// Shared types, constants and tables of the log-spiral tile map.
// Used by the cell modules and the top level; depends on nothing.
`default_nettype none
package lsm_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int FRAC_BITS_DEF     = 16;

  localparam int CX_W     = 52;   // CORDIC x/y: Q16.16 input times 2^16 plus growth
  localparam int ANG_W    = 35;   // angle in turns, 32 fraction bits
  localparam int M_W      = 64;   // |z|^2
  localparam int P_W      = 6;    // leading-one position
  localparam int LOG_FRAC = 24;
  localparam int MANT_W   = 32;
  localparam int W_W      = P_W + LOG_FRAC;
  localparam int PROD_W   = 60;
  localparam int L_W      = 32;   // Re(L), Im(L)
  localparam int PER_W    = 16;
  localparam int XP_W     = PER_W + L_W;
  localparam int SUM_W    = XP_W + 2;
  localparam int OUT_W    = 32;

  // squares, sum, normalize, log steps, scale product, rounding
  localparam int LOG_LAT  = 2 + 6 + LOG_FRAC + 2;

  localparam logic signed [W_W-1:0] LN2_OVER_2PI = W_W'(473811343);
  localparam logic signed [ANG_W-1:0] HALF_TURN  = ANG_W'(64'd1 << 31);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_Y = CFG_IDX_W'(1);
  localparam logic signed [PER_W-1:0] PERIOD_X_RST = PER_W'(256);
  localparam logic signed [PER_W-1:0] PERIOD_Y_RST = PER_W'(0);

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [CX_W-1:0]  x;
    logic signed [CX_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
  } cordic_t;

  typedef struct packed {
    logic [M_W-1:0] m;
    logic [P_W-1:0] p;
  } norm_t;

  typedef struct packed {
    logic [MANT_W-1:0]   mant;
    logic [LOG_FRAC-1:0] frac;
    logic [P_W-1:0]      p;
  } lg_t;

  typedef struct packed {
    logic vld;
    logic finite;
    logic zero;
  } flags_t;

endpackage
`default_nettype wire

>>> hw/rtl/lsm_in_if.sv
// Input channel: one complex point per request.
// Depends on nothing.
`default_nettype none
interface lsm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] z_re;
  logic signed [31:0] z_im;
  logic               z_finite;
  modport source (output valid, z_re, z_im, z_finite, input ready);
  modport sink   (input valid, z_re, z_im, z_finite, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lsm_out_if.sv
// Result channel: mapped point and clip flag per request.
// Depends on nothing.
`default_nettype none
interface lsm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] u_out;
  logic signed [31:0] v_out;
  logic               clipped;
  modport source (output valid, u_out, v_out, clipped, input ready);
  modport sink   (input valid, u_out, v_out, clipped, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lsm_cfg_if.sv
// Configuration write channel: register index and 16-bit data.
// Depends on nothing.
`default_nettype none
interface lsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lsm_cordic_cell.sv
// One CORDIC vectoring iteration with its output register.
// Depends on lsm_pkg.
`default_nettype none
module lsm_cordic_cell #(
  parameter int STAGE = 0
) (
  input  wire                   clk,
  input  wire                   en,
  input  lsm_pkg::cordic_t      c_in,
  output lsm_pkg::cordic_t      c_out
);
  localparam logic signed [lsm_pkg::ANG_W-1:0] STEP =
    lsm_pkg::ANG_W'(lsm_pkg::ATAN_TURNS[STAGE % 32]);

  lsm_pkg::cordic_t c_r, c_nxt;
  logic signed [lsm_pkg::CX_W-1:0] dx, dy;

  always_comb begin
    dx = c_in.y >>> STAGE;
    dy = c_in.x >>> STAGE;
    if (c_in.y > 0) begin
      c_nxt.x   = c_in.x + dx;
      c_nxt.y   = c_in.y - dy;
      c_nxt.ang = c_in.ang + STEP;
    end else begin
      c_nxt.x   = c_in.x - dx;
      c_nxt.y   = c_in.y + dy;
      c_nxt.ang = c_in.ang - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (en) c_r <= c_nxt;
  end

  assign c_out = c_r;
endmodule
`default_nettype wire

>>> hw/rtl/lsm_norm_cell.sv
// One step of the leading-one normalization of |z|^2.
// Depends on lsm_pkg.
`default_nettype none
module lsm_norm_cell #(
  parameter int SHIFT = 1
) (
  input  wire             clk,
  input  wire             en,
  input  lsm_pkg::norm_t  n_in,
  output lsm_pkg::norm_t  n_out
);
  lsm_pkg::norm_t n_r, n_nxt;

  always_comb begin
    n_nxt = n_in;
    // shift left by SHIFT if the top SHIFT bits are clear
    if (n_in.m[lsm_pkg::M_W-1 -: SHIFT] == '0) begin
      n_nxt.m = n_in.m << SHIFT;
      n_nxt.p = n_in.p - lsm_pkg::P_W'(SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) n_r <= n_nxt;
  end

  assign n_out = n_r;
endmodule
`default_nettype wire

>>> hw/rtl/lsm_log_cell.sv
// One fraction bit of log2 by mantissa squaring.
// Depends on lsm_pkg.
`default_nettype none
module lsm_log_cell (
  input  wire           clk,
  input  wire           en,
  input  lsm_pkg::lg_t  l_in,
  output lsm_pkg::lg_t  l_out
);
  lsm_pkg::lg_t l_r, l_nxt;
  logic [2*lsm_pkg::MANT_W-1:0] sq;
  logic [lsm_pkg::MANT_W:0]     t;

  always_comb begin
    sq = (2*lsm_pkg::MANT_W)'(l_in.mant) * (2*lsm_pkg::MANT_W)'(l_in.mant);
    t  = sq[2*lsm_pkg::MANT_W-1 -: lsm_pkg::MANT_W+1];
    l_nxt.p = l_in.p;
    if (t[lsm_pkg::MANT_W]) begin
      l_nxt.mant = t[lsm_pkg::MANT_W:1];
      l_nxt.frac = {l_in.frac[lsm_pkg::LOG_FRAC-2:0], 1'b1};
    end else begin
      l_nxt.mant = t[lsm_pkg::MANT_W-1:0];
      l_nxt.frac = {l_in.frac[lsm_pkg::LOG_FRAC-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) l_r <= l_nxt;
  end

  assign l_out = l_r;
endmodule
`default_nettype wire

>>> hw/rtl/lsm_delay.sv
// Enabled delay line used to line up the angle and flag paths.
// Depends on nothing.
`default_nettype none
module lsm_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          en,
  input  wire  [W-1:0] d,
  output logic [W-1:0] q
);
  generate
    if (D == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [W-1:0] tap_r [D];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          for (int i = 0; i < D; i++) tap_r[i] <= '0;
        end else if (en) begin
          tap_r[0] <= d;
          for (int i = 1; i < D; i++) tap_r[i] <= tap_r[i-1];
        end
      end
      assign q = tap_r[D-1];
    end
  endgenerate
endmodule
`default_nettype wire

>>> hw/rtl/log_spiral_tile_map.sv
// Log-spiral tile map top level: u/v from ln(z)/(2*pi) and the two periods.
// Depends on lsm_pkg, the channel interfaces, the cell modules and lsm_delay.
//
//  channel  dir  payload                    handshake
//  in_ch    in   z_re, z_im, z_finite       valid/ready
//  out_ch   out  u_out, v_out, clipped      valid/ready
//  cfg_ch   in   index, data                valid/ready (ready always high)
//
// One point per cycle unless out_ch stalls. The log2 chain registers squares,
// sum, 6 normalize cells, 24 squaring cells, scale and round; the product and
// output stages follow. The CORDIC chain runs beside it, padded to match.
// Reset is synchronous; it clears valid flags and loads the period defaults.
// A stalled output holds every stage, and in_ch.ready drops with it.
`default_nettype none
module log_spiral_tile_map #(
  parameter int CORDIC_STAGES = lsm_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = lsm_pkg::FRAC_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  lsm_in_if.sink     in_ch,
  lsm_out_if.source  out_ch,
  lsm_cfg_if.sink    cfg_ch
);
  localparam int CW    = lsm_pkg::CX_W;
  localparam int AW    = lsm_pkg::ANG_W;
  localparam int LW    = lsm_pkg::L_W;
  localparam int SH_I  = 32 - FRAC_BITS;
  localparam int SH_R  = lsm_pkg::LOG_FRAC + 1 + 32 - FRAC_BITS;
  localparam int OSH   = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
  localparam int D_IM  = lsm_pkg::LOG_LAT - (CORDIC_STAGES + 2);
  localparam logic signed [AW:0] RND_I = (AW+1)'(1) << (SH_I - 1);
  localparam logic signed [lsm_pkg::PROD_W-1:0] RND_R =
    lsm_pkg::PROD_W'(1) << (SH_R - 1);
  localparam logic signed [lsm_pkg::SUM_W-1:0] RND_O =
    (OSH > 0) ? (lsm_pkg::SUM_W'(1) << ((OSH > 0) ? OSH - 1 : 0)) : '0;
  localparam logic signed [lsm_pkg::SUM_W-1:0] OMAX = lsm_pkg::SUM_W'(32'sh7FFFFFFF);
  localparam logic signed [lsm_pkg::SUM_W-1:0] OMIN = -(OMAX + lsm_pkg::SUM_W'(1));

  logic en;

  // configuration
  logic signed [lsm_pkg::PER_W-1:0] px_r, py_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= lsm_pkg::PERIOD_X_RST;
      py_r <= lsm_pkg::PERIOD_Y_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == lsm_pkg::REG_PERIOD_X) px_r <= $signed(cfg_ch.data);
      if (cfg_ch.index == lsm_pkg::REG_PERIOD_Y) py_r <= $signed(cfg_ch.data);
    end
  end

  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // CORDIC pre-rotation into the right half plane
  logic signed [CW-1:0] x0, y0;
  lsm_pkg::cordic_t pre_r, pre_nxt;
  always_comb begin
    x0 = {{(CW-48){in_ch.z_re[31]}}, in_ch.z_re, 16'b0};
    y0 = {{(CW-48){in_ch.z_im[31]}}, in_ch.z_im, 16'b0};
    if (in_ch.z_re[31]) begin
      pre_nxt.x   = -x0;
      pre_nxt.y   = -y0;
      pre_nxt.ang = in_ch.z_im[31] ? -lsm_pkg::HALF_TURN : lsm_pkg::HALF_TURN;
    end else begin
      pre_nxt.x   = x0;
      pre_nxt.y   = y0;
      pre_nxt.ang = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) pre_r <= pre_nxt;
  end

  lsm_pkg::cordic_t cs [CORDIC_STAGES+1];
  assign cs[0] = pre_r;
  generate
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      lsm_cordic_cell #(.STAGE(i)) u_cell (
        .clk(clk), .en(en), .c_in(cs[i]), .c_out(cs[i+1])
      );
    end
  endgenerate

  logic signed [LW-1:0] im_l_r, im_l_d;
  logic signed [AW:0]   ang_ext;
  assign ang_ext = (AW+1)'(cs[CORDIC_STAGES].ang) + RND_I;
  always_ff @(posedge clk) begin
    if (en) im_l_r <= LW'(ang_ext >>> SH_I);
  end

  lsm_delay #(.W(LW), .D(D_IM)) u_im_dly (
    .clk(clk), .rst_n(rst_n), .en(en), .d(im_l_r), .q(im_l_d)
  );

  // log2 |z|^2 path
  logic [31:0] ar, ai;
  logic [lsm_pkg::M_W-1:0] ar2_r, ai2_r;
  lsm_pkg::norm_t n0_r;
  lsm_pkg::norm_t ns [7];
  assign ar = in_ch.z_re[31] ? 32'(-in_ch.z_re) : in_ch.z_re;
  assign ai = in_ch.z_im[31] ? 32'(-in_ch.z_im) : in_ch.z_im;
  always_ff @(posedge clk) begin
    if (en) begin
      ar2_r   <= lsm_pkg::M_W'(ar) * lsm_pkg::M_W'(ar);
      ai2_r   <= lsm_pkg::M_W'(ai) * lsm_pkg::M_W'(ai);
      n0_r.m  <= ar2_r + ai2_r;
      n0_r.p  <= lsm_pkg::P_W'(63);
    end
  end
  assign ns[0] = n0_r;

  generate
    for (genvar k = 0; k < 6; k++) begin : g_norm
      lsm_norm_cell #(.SHIFT(32 >> k)) u_cell (
        .clk(clk), .en(en), .n_in(ns[k]), .n_out(ns[k+1])
      );
    end
  endgenerate

  lsm_pkg::lg_t ls [lsm_pkg::LOG_FRAC+1];
  assign ls[0].mant = ns[6].m[lsm_pkg::M_W-1 -: lsm_pkg::MANT_W];
  assign ls[0].frac = '0;
  assign ls[0].p    = ns[6].p;
  generate
    for (genvar k = 0; k < lsm_pkg::LOG_FRAC; k++) begin : g_log
      lsm_log_cell u_cell (.clk(clk), .en(en), .l_in(ls[k]), .l_out(ls[k+1]));
    end
  endgenerate

  logic signed [lsm_pkg::W_W-1:0]    w;
  logic signed [lsm_pkg::PROD_W-1:0] prod_r;
  logic signed [LW-1:0]              re_l_r;
  // p - 32 in two's complement is p with its top bit flipped
  assign w = $signed({~ls[lsm_pkg::LOG_FRAC].p[lsm_pkg::P_W-1],
                      ls[lsm_pkg::LOG_FRAC].p[lsm_pkg::P_W-2:0],
                      ls[lsm_pkg::LOG_FRAC].frac});
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= w * lsm_pkg::LN2_OVER_2PI;
      re_l_r <= LW'((prod_r + RND_R) >>> SH_R);
    end
  end

  // flags ride beside the log path
  lsm_pkg::flags_t fl_in, fl_d;
  assign fl_in.vld    = in_ch.valid;
  assign fl_in.finite = in_ch.z_finite;
  assign fl_in.zero   = (in_ch.z_re == '0) && (in_ch.z_im == '0);
  lsm_delay #(.W($bits(lsm_pkg::flags_t)), .D(lsm_pkg::LOG_LAT)) u_fl_dly (
    .clk(clk), .rst_n(rst_n), .en(en), .d(fl_in), .q(fl_d)
  );

  // product stage
  logic signed [LW-1:0] re_s, im_s;
  logic signed [lsm_pkg::XP_W-1:0] pu1_r, pu2_r, pv1_r, pv2_r;
  logic vld_p_r, fin_p_r, zero_p_r;
  always_comb begin
    if (!fl_d.finite) begin
      re_s = '0;
      im_s = '0;
    end else if (fl_d.zero) begin
      re_s = {1'b1, {(LW-1){1'b0}}};
      im_s = '0;
    end else begin
      re_s = re_l_r;
      im_s = im_l_d;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vld_p_r <= 1'b0;
    else if (en) vld_p_r <= fl_d.vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      fin_p_r  <= fl_d.finite;
      zero_p_r <= fl_d.zero;
      pu1_r    <= px_r * im_s;
      pu2_r    <= py_r * re_s;
      pv1_r    <= px_r * re_s;
      pv2_r    <= py_r * im_s;
    end
  end

  // sum, round, saturate
  logic signed [lsm_pkg::SUM_W-1:0] su, sv;
  logic signed [lsm_pkg::OUT_W-1:0] u_nxt, v_nxt;
  logic clip_nxt;
  always_comb begin
    su = (lsm_pkg::SUM_W'(pu1_r) + lsm_pkg::SUM_W'(pu2_r) + RND_O) >>> OSH;
    sv = (lsm_pkg::SUM_W'(pv1_r) - lsm_pkg::SUM_W'(pv2_r) + RND_O) >>> OSH;
    clip_nxt = fin_p_r && zero_p_r;
    priority if (su > OMAX) begin
      u_nxt = 32'sh7FFFFFFF; clip_nxt = 1'b1;
    end else if (su < OMIN) begin
      u_nxt = 32'sh80000000; clip_nxt = 1'b1;
    end else begin
      u_nxt = lsm_pkg::OUT_W'(su);
    end
    priority if (sv > OMAX) begin
      v_nxt = 32'sh7FFFFFFF; clip_nxt = 1'b1;
    end else if (sv < OMIN) begin
      v_nxt = 32'sh80000000; clip_nxt = 1'b1;
    end else begin
      v_nxt = lsm_pkg::OUT_W'(sv);
    end
  end

  logic signed [lsm_pkg::OUT_W-1:0] u_r, v_r;
  logic clip_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vld_p_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.u_out   = u_r;
  assign out_ch.v_out   = v_r;
  assign out_ch.clipped = clip_r;

`ifndef SYNTH
  a_nonfinite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_p_r && !fin_p_r) |=> (out_valid_r && u_r == '0 && v_r == '0 && !clip_r))
    else $error("non-finite point did not map to zero");
  a_origin_clips: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_p_r && fin_p_r && zero_p_r) |=> (out_valid_r && clip_r))
    else $error("point at origin did not raise clipped");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> ($stable(vld_p_r) && $stable(pu1_r)))
    else $error("product stage moved during output stall");
`endif
endmodule
`default_nettype wire
